FILE: design/spi_nor_flash_command_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define SNFCS_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define SNFCS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Transfer types, opcode and result codes, flash command bytes and the
// frame lookup functions shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package snfcs_pkg;

    // Request and response opcodes of the input channel.
    localparam logic [3:0] OPC_READ_ID       = 4'd0;
    localparam logic [3:0] OPC_READ_DATA     = 4'd1;
    localparam logic [3:0] OPC_WR_ENABLE     = 4'd2;
    localparam logic [3:0] OPC_WR_DISABLE    = 4'd3;
    localparam logic [3:0] OPC_READ_STATUS   = 4'd4;
    localparam logic [3:0] OPC_ERASE         = 4'd5;
    localparam logic [3:0] OPC_PROGRAM_START = 4'd6;
    localparam logic [3:0] OPC_PROGRAM_BYTE  = 4'd7;
    localparam logic [3:0] OPC_RX_BYTE       = 4'd8;

    // Result kinds.
    localparam logic [1:0] KIND_BUS  = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_WREN      = 4'd1;
    localparam logic [3:0] PH_CMD       = 4'd2;
    localparam logic [3:0] PH_DATA      = 4'd3;
    localparam logic [3:0] PH_PAY_WAIT  = 4'd4;
    localparam logic [3:0] PH_PAY_RX    = 4'd5;
    localparam logic [3:0] PH_POLL_CMD  = 4'd6;
    localparam logic [3:0] PH_POLL_DATA = 4'd7;
    localparam logic [3:0] PH_WRDI      = 4'd8;

    // Flash command bytes.
    localparam logic [7:0] CMD_READ_ID     = 8'h90;
    localparam logic [7:0] CMD_READ_DATA   = 8'h03;
    localparam logic [7:0] CMD_WR_ENABLE   = 8'h06;
    localparam logic [7:0] CMD_WR_DISABLE  = 8'h04;
    localparam logic [7:0] CMD_READ_STATUS = 8'h05;
    localparam logic [7:0] CMD_ERASE       = 8'h20;
    localparam logic [7:0] CMD_PROGRAM     = 8'h02;
    localparam logic [7:0] BYTE_FILLER     = 8'hFF;
    localparam logic [7:0] BYTE_ID_MANUF   = 8'h08;
    localparam logic [7:0] BYTE_ID_DEVICE  = 8'h04;
    localparam logic [7:0] STATUS_BUSY     = 8'h01;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        payload_last;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       frame_end;
        logic       host_last;
        logic       last;
    } result_t;

    // Results produced by one accepted item, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] value,
                                          input logic fe, input logic hl);
        result_t r;
        r.kind      = kind;
        r.value     = value;
        r.frame_end = fe;
        r.host_last = hl;
        r.last      = 1'b0;
        return r;
    endfunction

    // Number of bytes in the command frame of an operation.
    function automatic logic [2:0] frame_len(input logic [2:0] op);
        logic [2:0] len;
        if (op == OPC_READ_ID[2:0]) begin
            len = 3'd6;
        end else if (op == OPC_WR_ENABLE[2:0] || op == OPC_WR_DISABLE[2:0]) begin
            len = 3'd1;
        end else if (op == OPC_READ_STATUS[2:0]) begin
            len = 3'd2;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Bus byte at a given position of an operation's command frame.
    function automatic logic [7:0] frame_byte(input logic [2:0] op, input logic [2:0] idx,
                                              input logic [23:0] addr);
        logic [7:0] b;
        logic [7:0] cmd;
        cmd = CMD_PROGRAM;
        if (op == OPC_READ_DATA[2:0]) begin
            cmd = CMD_READ_DATA;
        end else if (op == OPC_ERASE[2:0]) begin
            cmd = CMD_ERASE;
        end
        if (op == OPC_READ_ID[2:0]) begin
            unique case (idx)
                3'd0:    b = CMD_READ_ID;
                3'd4:    b = BYTE_ID_MANUF;
                3'd5:    b = BYTE_ID_DEVICE;
                default: b = 8'h00;
            endcase
        end else if (op == OPC_WR_ENABLE[2:0]) begin
            b = CMD_WR_ENABLE;
        end else if (op == OPC_WR_DISABLE[2:0]) begin
            b = CMD_WR_DISABLE;
        end else if (op == OPC_READ_STATUS[2:0]) begin
            b = (idx == 3'd0) ? CMD_READ_STATUS : BYTE_FILLER;
        end else begin
            unique case (idx)
                3'd0:    b = cmd;
                3'd1:    b = addr[23:16];
                3'd2:    b = addr[15:8];
                default: b = addr[7:0];
            endcase
        end
        return b;
    endfunction

    // Chip select rises after this frame byte.
    function automatic logic frame_ends(input logic [2:0] op, input logic [2:0] idx,
                                        input logic rem_zero);
        logic fe;
        if (({1'b0, idx} + 4'd1) < {1'b0, frame_len(op)}) begin
            fe = 1'b0;
        end else if (op == OPC_READ_DATA[2:0]) begin
            fe = rem_zero;
        end else if (op == OPC_PROGRAM_START[2:0]) begin
            fe = 1'b0;
        end else begin
            fe = 1'b1;
        end
        return fe;
    endfunction

endpackage

`default_nettype wire

FILE: design/snfcs_core.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Holds the sequencer state and turns one accepted transfer into a state
// update and up to two results in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_nor_flash_command_sequencer_top_macros.svh"

module snfcs_core
    import snfcs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire item_t in_item,
    output push_t      push
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  operation_reg, operation_next;
    logic [23:0] address_reg, address_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [2:0]  frame_index_reg, frame_index_next;
    logic        payload_done_reg, payload_done_next;

    logic [1:0]  n;
    result_t     r0, r1;
    logic [15:0] rem_dec;
    logic [2:0]  idx_inc;

    assign rem_dec = remaining_reg - 16'd1;
    assign idx_inc = frame_index_reg + 3'd1;

    // Next state and results for the transfer at the input.
    always_comb begin
        phase_next        = phase_reg;
        operation_next    = operation_reg;
        address_next      = address_reg;
        remaining_next    = remaining_reg;
        frame_index_next  = frame_index_reg;
        payload_done_next = payload_done_reg;
        n  = 2'd0;
        r0 = '0;
        r1 = '0;

        priority if (in_item.opcode <= OPC_PROGRAM_START && phase_reg == PH_IDLE) begin
            // New request: latch its parameters and open the first frame.
            operation_next    = in_item.opcode[2:0];
            address_next      = in_item.address;
            remaining_next    = (in_item.opcode == OPC_READ_DATA) ? in_item.length : 16'd0;
            payload_done_next = 1'b0;
            frame_index_next  = 3'd0;
            n = 2'd1;
            if (in_item.opcode == OPC_ERASE || in_item.opcode == OPC_PROGRAM_START) begin
                phase_next = PH_WREN;
                r0 = mk_result(KIND_BUS, CMD_WR_ENABLE, 1'b1, 1'b0);
            end else begin
                phase_next = PH_CMD;
                r0 = mk_result(KIND_BUS,
                               frame_byte(in_item.opcode[2:0], 3'd0, in_item.address),
                               frame_ends(in_item.opcode[2:0], 3'd0, in_item.length == 16'd0),
                               1'b0);
            end
        end else if (in_item.opcode == OPC_PROGRAM_BYTE && phase_reg == PH_PAY_WAIT) begin
            // Program payload byte goes straight onto the bus.
            payload_done_next = in_item.payload_last;
            phase_next = PH_PAY_RX;
            n  = 2'd1;
            r0 = mk_result(KIND_BUS, in_item.data_byte, in_item.payload_last, 1'b0);
        end else if (in_item.opcode == OPC_RX_BYTE && phase_reg != PH_IDLE
                     && phase_reg != PH_PAY_WAIT) begin
            // Response to the last bus byte sent.
            unique case (phase_reg)
                PH_WREN: begin
                    frame_index_next = 3'd0;
                    phase_next = PH_CMD;
                    n  = 2'd1;
                    r0 = mk_result(KIND_BUS, frame_byte(operation_reg, 3'd0, address_reg),
                                   frame_ends(operation_reg, 3'd0, remaining_reg == 16'd0),
                                   1'b0);
                end
                PH_CMD: begin
                    priority if (operation_reg == OPC_READ_ID[2:0]
                                 && frame_index_reg == 3'd4) begin
                        frame_index_next = 3'd5;
                        n  = 2'd2;
                        r0 = mk_result(KIND_HOST, in_item.data_byte, 1'b0, 1'b0);
                        r1 = mk_result(KIND_BUS, frame_byte(operation_reg, 3'd5, address_reg),
                                       frame_ends(operation_reg, 3'd5,
                                                  remaining_reg == 16'd0), 1'b0);
                    end else if ((operation_reg == OPC_READ_ID[2:0] && frame_index_reg >= 3'd5)
                                 || (operation_reg == OPC_READ_STATUS[2:0]
                                     && frame_index_reg >= 3'd1)) begin
                        phase_next = PH_IDLE;
                        n  = 2'd2;
                        r0 = mk_result(KIND_HOST, in_item.data_byte, 1'b0, 1'b1);
                        r1 = mk_result(KIND_DONE, 8'h00, 1'b0, 1'b0);
                    end else if (({1'b0, frame_index_reg} + 4'd1)
                                 < {1'b0, frame_len(operation_reg)}) begin
                        frame_index_next = idx_inc;
                        n  = 2'd1;
                        r0 = mk_result(KIND_BUS, frame_byte(operation_reg, idx_inc, address_reg),
                                       frame_ends(operation_reg, idx_inc,
                                                  remaining_reg == 16'd0), 1'b0);
                    end else if (operation_reg == OPC_READ_DATA[2:0]) begin
                        n = 2'd1;
                        if (remaining_reg == 16'd0) begin
                            phase_next = PH_IDLE;
                            r0 = mk_result(KIND_DONE, 8'h00, 1'b0, 1'b0);
                        end else begin
                            phase_next = PH_DATA;
                            r0 = mk_result(KIND_BUS, BYTE_FILLER, remaining_reg == 16'd1, 1'b0);
                        end
                    end else if (operation_reg == OPC_ERASE[2:0]) begin
                        phase_next = PH_POLL_CMD;
                        n  = 2'd1;
                        r0 = mk_result(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
                    end else if (operation_reg == OPC_PROGRAM_START[2:0]) begin
                        // Address sent; the frame stays open for the payload.
                        phase_next = PH_PAY_WAIT;
                    end else begin
                        phase_next = PH_IDLE;
                        n  = 2'd1;
                        r0 = mk_result(KIND_DONE, 8'h00, 1'b0, 1'b0);
                    end
                end
                PH_DATA: begin
                    remaining_next = rem_dec;
                    n  = 2'd2;
                    r0 = mk_result(KIND_HOST, in_item.data_byte, 1'b0, rem_dec == 16'd0);
                    if (rem_dec == 16'd0) begin
                        phase_next = PH_IDLE;
                        r1 = mk_result(KIND_DONE, 8'h00, 1'b0, 1'b0);
                    end else begin
                        r1 = mk_result(KIND_BUS, BYTE_FILLER, rem_dec == 16'd1, 1'b0);
                    end
                end
                PH_PAY_RX: begin
                    if (payload_done_reg) begin
                        phase_next = PH_POLL_CMD;
                        n  = 2'd1;
                        r0 = mk_result(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
                    end else begin
                        phase_next = PH_PAY_WAIT;
                    end
                end
                PH_POLL_CMD: begin
                    phase_next = PH_POLL_DATA;
                    n  = 2'd1;
                    r0 = mk_result(KIND_BUS, BYTE_FILLER, 1'b1, 1'b0);
                end
                PH_POLL_DATA: begin
                    n = 2'd1;
                    if ((in_item.data_byte & STATUS_BUSY) != 8'h00) begin
                        phase_next = PH_POLL_CMD;
                        r0 = mk_result(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
                    end else begin
                        phase_next = PH_WRDI;
                        r0 = mk_result(KIND_BUS, CMD_WR_DISABLE, 1'b1, 1'b0);
                    end
                end
                default: begin
                    // Write disable answered: the operation is complete.
                    phase_next = PH_IDLE;
                    n  = 2'd1;
                    r0 = mk_result(KIND_DONE, 8'h00, 1'b0, 1'b0);
                end
            endcase
        end else begin
            // Request in the wrong phase or an unknown opcode.
            n  = 2'd1;
            r0 = mk_result(KIND_ERR, 8'h00, 1'b0, 1'b0);
        end
    end

    // Mark the final result of the transfer and gate by acceptance.
    always_comb begin
        push.count = in_valid ? n : 2'd0;
        push.r0    = r0;
        push.r1    = r1;
        push.r0.last = (n == 2'd1);
        push.r1.last = (n == 2'd2);
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            operation_reg    <= 3'd0;
            address_reg      <= 24'd0;
            remaining_reg    <= 16'd0;
            frame_index_reg  <= 3'd0;
            payload_done_reg <= 1'b0;
        end else if (in_valid) begin
            phase_reg        <= phase_next;
            operation_reg    <= operation_next;
            address_reg      <= address_next;
            remaining_reg    <= remaining_next;
            frame_index_reg  <= frame_index_next;
            payload_done_reg <= payload_done_next;
        end
    end

    `SNFCS_ASSERT_NOW(a_phase_legal, aclk, aresetn, 1'b1, phase_reg <= PH_WRDI,
                      "sequencer phase outside the defined range")
    `SNFCS_ASSERT_NOW(a_data_has_bytes, aclk, aresetn, phase_reg == PH_DATA,
                      remaining_reg != 16'd0, "read data phase with no bytes left")

endmodule

`default_nettype wire

FILE: design/snfcs_fifo.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer result queue
// Small register queue that takes up to two results per cycle and hands
// out one per transfer on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_nor_flash_command_sequencer_top_macros.svh"

module snfcs_fifo
    import snfcs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       room,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    m_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_second;
    logic          rd;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Space for a full pair of results is kept free for the next transfer.
    assign room    = (count_reg <= CW'(DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign rd      = m_valid && m_ready;

    assign wr_ptr_second = ptr_inc(wr_ptr_reg);

    // Pointer and fill level update.
    always_comb begin
        unique case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_second;
            default: wr_ptr_next = ptr_inc(wr_ptr_second);
        endcase
        rd_ptr_next = rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_second] <= push.r1;
        end
    end

    `SNFCS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH),
                      "result queue fill level beyond its depth")
    `SNFCS_ASSERT_NOW(a_push_fits, aclk, aresetn, push.count != 2'd0,
                      count_reg <= CW'(DEPTH - 2), "results pushed without room for a pair")
    `SNFCS_ASSERT_NEXT(a_pop_drains, aclk, aresetn, rd && push.count == 2'd0,
                       count_reg == $past(count_reg) - CW'(1),
                       "result transfer did not lower the fill level")

endmodule

`default_nettype wire

FILE: design/spi_nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer top level
// Byte-level master command sequencer for SPI NOR flash devices.
// ----------------------------------------------------------------------------
// The block takes one request or response transfer per cycle whenever the
// result queue has room for two results (s_ready is high while it holds at
// most FIFO_DEPTH-2 entries). Each input transfer is processed in the cycle
// it is accepted and yields zero, one or two results, which leave through
// the m_ channel at one result per cycle while m_ready is high; the result
// channel therefore sets the sustained rate, which depends on how many
// results the items produce. Result order matches input order.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_nor_flash_command_sequencer_top
    import snfcs_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    m_data
);

    push_t push;
    logic  accept;

    assign accept = s_valid && s_ready;

    // State machine and result generation.
    snfcs_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_item  (s_data),
        .push     (push)
    );

    // Result queue toward the output channel.
    snfcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: verif/spi_nor_flash_command_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Drives host requests, program payload bytes and flash replies into the
// sequencer. A cycle-free copy of the sequencing rules predicts every bus
// byte, host byte, done and phase error result. A checker compares each
// result transfer with the oldest prediction. Both channels idle at random,
// and one long receiver hold-off fills the result queue.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_top_tb;
    import snfcs_pkg::*;

    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    item_t   s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;

    // Shared controls for the idle pattern and the long receiver hold-off.
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    // Bookkeeping.
    result_t expected_results[$];
    result_t step_out[$];
    int      items_sent      = 0;
    int      results_checked = 0;
    int      mismatch_count  = 0;
    int      kind_count[4]   = '{0, 0, 0, 0};
    int      quiet_cycles    = 0;

    // Predicted sequencer state.
    logic [3:0]  seq_phase    = PH_IDLE;
    logic [3:0]  seq_op       = OPC_READ_ID;
    logic [23:0] seq_addr     = '0;
    logic [15:0] seq_left     = '0;
    logic [2:0]  seq_idx      = '0;
    logic        seq_pay_last = 1'b0;

    spi_nor_flash_command_sequencer_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value,
                                 input logic fe, input logic hl);
        result_t r;
        r.kind      = kind;
        r.value     = value;
        r.frame_end = fe;
        r.host_last = hl;
        r.last      = 1'b0;
        step_out.push_back(r);
    endfunction

    // Length of the command frame of the current operation.
    function automatic int cmd_frame_len();
        int len;
        case (seq_op)
            OPC_READ_ID:                    len = 6;
            OPC_WR_ENABLE, OPC_WR_DISABLE:  len = 1;
            OPC_READ_STATUS:                len = 2;
            default:                        len = 4;
        endcase
        return len;
    endfunction

    // Byte at position idx of the current command frame.
    function automatic logic [7:0] cmd_frame_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (seq_op)
            OPC_READ_ID: begin
                if (idx == 3'd0) begin
                    b = CMD_READ_ID;
                end else if (idx == 3'd4) begin
                    b = BYTE_ID_MANUF;
                end else if (idx == 3'd5) begin
                    b = BYTE_ID_DEVICE;
                end else begin
                    b = 8'h00;
                end
            end
            OPC_WR_ENABLE:   b = CMD_WR_ENABLE;
            OPC_WR_DISABLE:  b = CMD_WR_DISABLE;
            OPC_READ_STATUS: b = (idx == 3'd0) ? CMD_READ_STATUS : BYTE_FILLER;
            default: begin
                if (idx == 3'd0) begin
                    b = (seq_op == OPC_READ_DATA) ? CMD_READ_DATA :
                        (seq_op == OPC_ERASE) ? CMD_ERASE : CMD_PROGRAM;
                end else if (idx == 3'd1) begin
                    b = seq_addr[23:16];
                end else if (idx == 3'd2) begin
                    b = seq_addr[15:8];
                end else begin
                    b = seq_addr[7:0];
                end
            end
        endcase
        return b;
    endfunction

    // Emit one command frame byte; chip select rises after the last one unless
    // read data or a program payload follows in the same frame.
    function automatic void issue_cmd_byte(input logic [2:0] idx);
        logic closes;
        if (int'(idx) + 1 < cmd_frame_len()) begin
            closes = 1'b0;
        end else if (seq_op == OPC_READ_DATA) begin
            closes = (seq_left == 16'd0);
        end else if (seq_op == OPC_PROGRAM_START) begin
            closes = 1'b0;
        end else begin
            closes = 1'b1;
        end
        seq_idx   = idx;
        seq_phase = PH_CMD;
        emit(KIND_BUS, cmd_frame_byte(idx), closes, 1'b0);
    endfunction

    function automatic void finish_operation();
        emit(KIND_DONE, 8'h00, 1'b0, 1'b0);
        seq_phase = PH_IDLE;
    endfunction

    // Flash reply to a command frame byte.
    function automatic void cmd_byte_answered(input logic [7:0] rx);
        if (seq_op == OPC_READ_ID && seq_idx == 3'd4) begin
            emit(KIND_HOST, rx, 1'b0, 1'b0);
            issue_cmd_byte(3'd5);
        end else if ((seq_op == OPC_READ_ID && seq_idx >= 3'd5) ||
                     (seq_op == OPC_READ_STATUS && seq_idx >= 3'd1)) begin
            emit(KIND_HOST, rx, 1'b0, 1'b1);
            finish_operation();
        end else if (int'(seq_idx) + 1 < cmd_frame_len()) begin
            issue_cmd_byte(seq_idx + 3'd1);
        end else if (seq_op == OPC_READ_DATA) begin
            if (seq_left == 16'd0) begin
                finish_operation();
            end else begin
                seq_phase = PH_DATA;
                emit(KIND_BUS, BYTE_FILLER, seq_left == 16'd1, 1'b0);
            end
        end else if (seq_op == OPC_ERASE) begin
            seq_phase = PH_POLL_CMD;
            emit(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
        end else if (seq_op == OPC_PROGRAM_START) begin
            seq_phase = PH_PAY_WAIT;
        end else begin
            finish_operation();
        end
    endfunction

    // Advance the predicted state by one accepted item and queue its results.
    function automatic void sequencer_step(input item_t it);
        step_out.delete();
        if (it.opcode <= OPC_PROGRAM_START && seq_phase == PH_IDLE) begin
            seq_op       = it.opcode;
            seq_addr     = it.address;
            seq_left     = (it.opcode == OPC_READ_DATA) ? it.length : 16'd0;
            seq_pay_last = 1'b0;
            if (it.opcode == OPC_ERASE || it.opcode == OPC_PROGRAM_START) begin
                seq_idx   = 3'd0;
                seq_phase = PH_WREN;
                emit(KIND_BUS, CMD_WR_ENABLE, 1'b1, 1'b0);
            end else begin
                issue_cmd_byte(3'd0);
            end
        end else if (it.opcode == OPC_PROGRAM_BYTE && seq_phase == PH_PAY_WAIT) begin
            seq_pay_last = it.payload_last;
            seq_phase    = PH_PAY_RX;
            emit(KIND_BUS, it.data_byte, it.payload_last, 1'b0);
        end else if (it.opcode == OPC_RX_BYTE && seq_phase != PH_IDLE &&
                     seq_phase != PH_PAY_WAIT) begin
            case (seq_phase)
                PH_WREN: issue_cmd_byte(3'd0);
                PH_CMD:  cmd_byte_answered(it.data_byte);
                PH_DATA: begin
                    seq_left = seq_left - 16'd1;
                    emit(KIND_HOST, it.data_byte, 1'b0, seq_left == 16'd0);
                    if (seq_left == 16'd0) begin
                        finish_operation();
                    end else begin
                        emit(KIND_BUS, BYTE_FILLER, seq_left == 16'd1, 1'b0);
                    end
                end
                PH_PAY_RX: begin
                    if (seq_pay_last) begin
                        seq_phase = PH_POLL_CMD;
                        emit(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
                    end else begin
                        seq_phase = PH_PAY_WAIT;
                    end
                end
                PH_POLL_CMD: begin
                    seq_phase = PH_POLL_DATA;
                    emit(KIND_BUS, BYTE_FILLER, 1'b1, 1'b0);
                end
                PH_POLL_DATA: begin
                    if ((it.data_byte & STATUS_BUSY) != 8'h00) begin
                        seq_phase = PH_POLL_CMD;
                        emit(KIND_BUS, CMD_READ_STATUS, 1'b0, 1'b0);
                    end else begin
                        seq_phase = PH_WRDI;
                        emit(KIND_BUS, CMD_WR_DISABLE, 1'b1, 1'b0);
                    end
                end
                default: finish_operation();
            endcase
        end else begin
            emit(KIND_ERR, 8'h00, 1'b0, 1'b0);
        end
        // The final result of the item carries the last flag.
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last = 1'b1;
        end
        foreach (step_out[i]) begin
            expected_results.push_back(step_out[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Every field random, so ignored fields toggle all their bits.
    function automatic item_t random_item();
        item_t it;
        it.opcode       = 4'($urandom_range(0, 15));
        it.address      = 24'($urandom_range(0, 24'hFFFFFF));
        it.length       = 16'($urandom_range(0, 16'hFFFF));
        it.data_byte    = 8'($urandom_range(0, 255));
        it.payload_last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t host_request(input logic [3:0] op, input int max_len);
        item_t it;
        it        = random_item();
        it.opcode = op;
        if (op == OPC_READ_DATA) begin
            it.length = 16'($urandom_range(0, max_len));
        end
        return it;
    endfunction

    // Well-formed next item: a payload byte when the sequencer waits for one,
    // otherwise the flash reply to the last bus byte.
    function automatic item_t flash_reply(input int busy_pct, input int last_pct);
        item_t it;
        it = random_item();
        if (seq_phase == PH_PAY_WAIT) begin
            it.opcode       = OPC_PROGRAM_BYTE;
            it.payload_last = ($urandom_range(0, 99) < last_pct);
        end else begin
            it.opcode = OPC_RX_BYTE;
            if (seq_phase == PH_POLL_DATA) begin
                it.data_byte[0] = ($urandom_range(0, 99) < busy_pct);
            end
        end
        return it;
    endfunction

    // Any opcode; a read started by it stays short.
    function automatic item_t stray_item();
        item_t it;
        it = random_item();
        if (it.opcode == OPC_READ_DATA) begin
            it.length = 16'($urandom_range(0, 8));
        end
        return it;
    endfunction

    // Offer one item, hold it until the transfer completes, then predict.
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sequencer_step(it);
        items_sent++;
    endtask

    task automatic send_reply(input logic [3:0] op, input logic [7:0] value);
        item_t it;
        it           = random_item();
        it.opcode    = op;
        it.data_byte = value;
        send_item(it);
    endtask

    task automatic finish_op(input int busy_pct);
        while (seq_phase != PH_IDLE) begin
            send_item(flash_reply(busy_pct, 30));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Payload bytes, flash replies and unknown opcodes while idle.
    task automatic test_misplaced_items();
        item_t it;
        send_reply(OPC_PROGRAM_BYTE, 8'hA5);
        send_reply(OPC_RX_BYTE, 8'h5A);
        for (int op = 9; op <= 15; op++) begin
            it        = random_item();
            it.opcode = 4'(op);
            if (op == 15) begin
                it = '1;
            end else if (op == 9) begin
                it        = '0;
                it.opcode = 4'(op);
            end
            send_item(it);
        end
    endtask

    // ID frame, with requests and a payload byte thrown in while busy.
    task automatic test_read_id();
        send_item(host_request(OPC_READ_ID, 0));
        send_reply(OPC_RX_BYTE, 8'h00);
        send_item(host_request(OPC_ERASE, 0));
        send_item(host_request(OPC_READ_DATA, 4));
        send_reply(OPC_PROGRAM_BYTE, 8'h11);
        send_reply(OPC_RX_BYTE, 8'hFF);
        send_reply(OPC_RX_BYTE, 8'h00);
        send_reply(OPC_RX_BYTE, 8'h3C);
        send_reply(OPC_RX_BYTE, 8'hEF);
        send_reply(OPC_RX_BYTE, 8'h17);
    endtask

    // Reads of zero, one and two bytes, the first two at the address extremes.
    task automatic test_read_data();
        item_t it;
        it         = host_request(OPC_READ_DATA, 0);
        it.address = 24'hFFFFFF;
        it.length  = 16'd0;
        send_item(it);
        finish_op(0);
        it         = host_request(OPC_READ_DATA, 0);
        it.address = 24'h000000;
        it.length  = 16'd1;
        send_item(it);
        finish_op(0);
        it        = host_request(OPC_READ_DATA, 0);
        it.length = 16'd2;
        send_item(it);
        finish_op(0);
    endtask

    task automatic test_single_frames();
        send_item(host_request(OPC_WR_ENABLE, 0));
        finish_op(0);
        send_item(host_request(OPC_WR_DISABLE, 0));
        finish_op(0);
        send_item(host_request(OPC_READ_STATUS, 0));
        send_reply(OPC_RX_BYTE, 8'h00);
        send_reply(OPC_RX_BYTE, 8'hFF);
    endtask

    // Erase with the status register reporting busy on most polls.
    task automatic test_erase();
        send_item(host_request(OPC_ERASE, 0));
        finish_op(75);
    endtask

    // Page program with a stray flash reply while the payload is awaited.
    task automatic test_program();
        send_item(host_request(OPC_PROGRAM_START, 0));
        while (seq_phase != PH_PAY_WAIT) begin
            send_item(flash_reply(0, 0));
        end
        send_reply(OPC_RX_BYTE, 8'h42);
        send_reply(OPC_PROGRAM_BYTE, 8'h00);
        send_item(flash_reply(0, 0));
        send_reply(OPC_PROGRAM_BYTE, 8'hFF);
        send_item(flash_reply(0, 0));
        finish_op(50);
    endtask

    task automatic test_long_read();
        item_t it;
        it        = host_request(OPC_READ_DATA, 0);
        it.length = 16'd260;
        send_item(it);
        finish_op(0);
    endtask

    // Well-formed operations with random content and a share of noise.
    task automatic test_random_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (seq_phase == PH_IDLE) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(stray_item());
                end else begin
                    send_item(host_request(4'($urandom_range(0, 6)), 6));
                end
            end else if ($urandom_range(0, 99) < 8) begin
                send_item(stray_item());
            end else begin
                send_item(flash_reply(40, 25));
            end
        end
        finish_op(40);
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        test_random_traffic(40);
        idle_on = 1'b1;
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(80);
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!idle_on) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transfer against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            kind_count[m_data.kind]++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("ERROR: unexpected result kind=%0d value=%02h fe=%b hl=%b last=%b",
                             m_data.kind, m_data.value, m_data.frame_end,
                             m_data.host_last, m_data.last);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_data.kind !== want.kind || m_data.value !== want.value ||
                    m_data.frame_end !== want.frame_end ||
                    m_data.host_last !== want.host_last || m_data.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"ERROR: result %0d expected kind=%0d value=%02h fe=%b hl=%b",
                                  " last=%b, got kind=%0d value=%02h fe=%b hl=%b last=%b"},
                                 results_checked, want.kind, want.value, want.frame_end,
                                 want.host_last, want.last, m_data.kind, m_data.value,
                                 m_data.frame_end, m_data.host_last, m_data.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_misplaced_items();
        test_read_id();
        test_read_data();
        test_single_frames();
        test_erase();
        test_program();
        test_long_read();
        test_random_traffic(140);
        test_backpressure();
        test_random_traffic(200);
        test_back_to_back();
        test_random_traffic(150);

        // Let every predicted result drain, then allow some settling time.
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items, checked %0d results: %0d bus, %0d host bytes,",
                 items_sent, results_checked, kind_count[KIND_BUS], kind_count[KIND_HOST]);
        $display("%0d completed operations and %0d phase errors; %0d mismatches.",
                 kind_count[KIND_DONE], kind_count[KIND_ERR], mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/snfcs_pkg.sv
design/snfcs_core.sv
design/snfcs_fifo.sv
design/spi_nor_flash_command_sequencer_top.sv
verif/spi_nor_flash_command_sequencer_top_tb.sv
